@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/hpbt_pkg.sv @@
// Shared constants, types and control structs of the percentile baseline tracker.
package hpbt_pkg;

  localparam int NUM_BINS    = 64;
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int IDX_W       = $clog2(NUM_BINS + 1);
  localparam int SAMPLE_BITS = 16;
  localparam int LEVEL_W     = SAMPLE_BITS - 1;
  localparam int RESID_W     = SAMPLE_BITS + 1;
  localparam int FRAC_W      = 16;
  localparam int WEIGHT_W    = FRAC_W + 1;
  localparam int PROD_W      = WEIGHT_W + FRAC_W;
  localparam int SUM_W       = WEIGHT_W + BIN_W;
  localparam int SHIFT_W     = 4;
  localparam int QUANT_W     = IDX_W + (1 << SHIFT_W) - 1;
  localparam int BASE_W      = 32;
  localparam int CFG_IDX_W   = 2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = WEIGHT_W'(1) << FRAC_W;
  localparam logic [SUM_W-1:0]    QUANT_THRESHOLD = SUM_W'(3277);
  localparam logic [LEVEL_W-1:0]  SAMPLE_MAX      = {LEVEL_W{1'b1}};

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_HIST_DECAY     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BASELINE_DECAY = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_SHIFT      = CFG_IDX_W'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIST,
    ST_MUL_A,
    ST_MUL_B,
    ST_ADD,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              start;
    logic              init;
    logic [BIN_W-1:0]  bin;
    logic [FRAC_W-1:0] decay;
  } hist_cmd_t;

  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] stop_idx;
  } hist_stat_t;

endpackage

@@ hw/rtl/hpbt_hist.sv @@
// Histogram memory with decay / percentile scan pipeline.
module hpbt_hist (
  input  logic                  clk,
  input  logic                  rst,
  input  hpbt_pkg::hist_cmd_t   cmd,
  output hpbt_pkg::hist_stat_t  stat
);

  logic [hpbt_pkg::WEIGHT_W-1:0] mem [hpbt_pkg::NUM_BINS];
  logic [hpbt_pkg::NUM_BINS-1:0] valid_bits;

  logic                          running;
  logic                          init_pend;
  logic [hpbt_pkg::BIN_W-1:0]    bin;
  logic [hpbt_pkg::FRAC_W-1:0]   decay;
  logic [hpbt_pkg::IDX_W-1:0]    rd_idx;

  logic                          s1_v;
  logic [hpbt_pkg::BIN_W-1:0]    s1_idx;
  logic [hpbt_pkg::WEIGHT_W-1:0] rdata;
  logic                          rvalid;

  logic                          s2_v;
  logic [hpbt_pkg::BIN_W-1:0]    s2_idx;
  logic                          s2_hit;
  logic [hpbt_pkg::PROD_W-1:0]   prod;

  logic                          s3_v;
  logic [hpbt_pkg::BIN_W-1:0]    s3_idx;
  logic [hpbt_pkg::WEIGHT_W-1:0] s3_new;

  logic [hpbt_pkg::SUM_W-1:0]    sum;
  logic                          found;
  logic [hpbt_pkg::IDX_W-1:0]    stop_reg;

  logic                          issue;
  logic                          wr_en;
  logic [hpbt_pkg::BIN_W-1:0]    wr_addr;
  logic [hpbt_pkg::WEIGHT_W-1:0] wr_data;
  logic [hpbt_pkg::WEIGHT_W-1:0] new_w;
  logic [hpbt_pkg::WEIGHT_W-1:0] bonus;
  logic [hpbt_pkg::SUM_W-1:0]    sum_next;
  logic                          reached;
  logic                          last;

  assign issue = running && (rd_idx < hpbt_pkg::IDX_W'(hpbt_pkg::NUM_BINS));

  // decayed weight; the chosen bin gets the complement of the decay
  assign bonus = hpbt_pkg::WEIGHT_ONE - {1'b0, decay};
  assign new_w = prod[hpbt_pkg::PROD_W-1:hpbt_pkg::FRAC_W]
               + (s2_hit ? bonus : '0);

  always_comb begin
    if (init_pend) begin
      wr_en   = 1'b1;
      wr_addr = bin;
      wr_data = hpbt_pkg::WEIGHT_ONE;
    end else begin
      wr_en   = s2_v;
      wr_addr = s2_idx;
      wr_data = new_w;
    end
  end

  assign sum_next = sum + hpbt_pkg::SUM_W'(s3_new);
  assign reached  = sum_next >= hpbt_pkg::QUANT_THRESHOLD;
  assign last     = s3_idx == hpbt_pkg::BIN_W'(hpbt_pkg::NUM_BINS - 1);

  // weight store: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rdata  <= mem[rd_idx[hpbt_pkg::BIN_W-1:0]];
      rvalid <= valid_bits[rd_idx[hpbt_pkg::BIN_W-1:0]];
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      bin   <= cmd.bin;
      decay <= cmd.decay;
    end
    s1_idx <= rd_idx[hpbt_pkg::BIN_W-1:0];
    s2_idx <= s1_idx;
    s2_hit <= s1_idx == bin;
    prod   <= hpbt_pkg::PROD_W'(rvalid ? rdata : '0) * hpbt_pkg::PROD_W'(decay);
    s3_idx <= s2_idx;
    s3_new <= new_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running    <= 1'b0;
      init_pend  <= 1'b0;
      rd_idx     <= '0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      s3_v       <= 1'b0;
      found      <= 1'b0;
      sum        <= '0;
      stop_reg   <= '0;
      valid_bits <= '0;
      stat       <= '0;
    end else begin
      stat.done <= 1'b0;
      s1_v      <= issue;
      s2_v      <= s1_v;
      s3_v      <= s2_v;

      if (cmd.start) begin
        if (cmd.init) begin
          init_pend <= 1'b1;
        end else begin
          running <= 1'b1;
          rd_idx  <= '0;
          found   <= 1'b0;
          sum     <= '0;
        end
      end

      if (init_pend) begin
        init_pend <= 1'b0;
        stat.done <= 1'b1;
      end

      if (issue) begin
        rd_idx <= rd_idx + hpbt_pkg::IDX_W'(1);
      end

      if (s3_v) begin
        if (!found) begin
          sum <= sum_next;
          if (reached) begin
            found    <= 1'b1;
            stop_reg <= hpbt_pkg::IDX_W'(s3_idx) + hpbt_pkg::IDX_W'(1);
          end
        end
        if (last) begin
          running       <= 1'b0;
          stat.done     <= 1'b1;
          // not reached before the last bin: stop index is the bin count
          stat.stop_idx <= found ? stop_reg : hpbt_pkg::IDX_W'(hpbt_pkg::NUM_BINS);
        end
      end

      if (wr_en) begin
        valid_bits[wr_addr] <= 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/histogram_percentile_baseline_tracker.sv @@
// Top level of the histogram percentile baseline tracker.
//
// Tracks a slowly moving baseline as the 5 percent lower quantile of an
// exponentially decaying histogram of nonnegative samples, and returns each
// sample minus the integer part of that baseline (unchanged while learning is
// off). Learning runs only while both hist_decay and baseline_decay are
// nonzero; then each nonnegative sample ages all 64 bins and adds its weight
// to bin (sample >> bin_shift), clamped to the last bin. The first such
// sample only seeds its bin and the baseline. Timing: one word is taken at a
// time. A word that does not learn goes from idle to the finish state; a
// learning word waits for the seed write or the single read-modify-write
// pass over the bin memory (one bin per cycle, three pipeline stages), then
// a regular one blends the baseline in the MUL_A, MUL_B and ADD states. The
// result sits in an output register, so a stalled result does not hold up
// the next word until that word finishes. The bin memory reads as zero after
// reset through per-bin valid flags, so no clearing pass is needed.
// Configuration may only be written while no word is in flight.
module histogram_percentile_baseline_tracker (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_write,
  input  logic [hpbt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hpbt_pkg::FRAC_W-1:0]            cfg_data,
  // sample word in
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [hpbt_pkg::SAMPLE_BITS-1:0] sample,
  // result word out
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [hpbt_pkg::RESID_W-1:0]    residual,
  output logic [hpbt_pkg::LEVEL_W-1:0]           baseline_level
);

  // config registers
  logic [hpbt_pkg::FRAC_W-1:0]      hist_decay;
  logic [hpbt_pkg::FRAC_W-1:0]      baseline_decay;
  logic [hpbt_pkg::SHIFT_W-1:0]     bin_shift;

  hpbt_pkg::state_t                 state;
  hpbt_pkg::state_t                 state_next;

  logic                             started;
  logic [hpbt_pkg::BASE_W-1:0]      baseline;
  logic [hpbt_pkg::SAMPLE_BITS-1:0] sample_reg;
  logic                             enabled_reg;
  logic                             init_reg;
  logic [hpbt_pkg::LEVEL_W-1:0]     q;
  logic [hpbt_pkg::BASE_W+hpbt_pkg::FRAC_W-1:0] prod_a;
  logic [hpbt_pkg::BASE_W-1:0]      prod_b;

  logic                             accept;
  logic                             enabled;
  logic                             learn;
  logic                             out_free;
  logic [hpbt_pkg::LEVEL_W-1:0]     mag;
  logic [hpbt_pkg::LEVEL_W-1:0]     shifted;
  logic [hpbt_pkg::BIN_W-1:0]       bin;
  logic [hpbt_pkg::QUANT_W-1:0]     q_wide;
  logic [hpbt_pkg::LEVEL_W-1:0]     q_sat;
  logic [hpbt_pkg::WEIGHT_W-1:0]    blend;
  logic [hpbt_pkg::LEVEL_W-1:0]     level;
  logic [hpbt_pkg::RESID_W-1:0]     resid_calc;

  hpbt_pkg::hist_cmd_t              cmd;
  hpbt_pkg::hist_stat_t             stat;

  assign in_stall = state != hpbt_pkg::ST_IDLE;
  assign accept   = in_valid && !in_stall;
  assign enabled  = (hist_decay != '0) && (baseline_decay != '0);
  assign learn    = enabled && !sample[hpbt_pkg::SAMPLE_BITS-1];
  assign out_free = !out_valid || !out_stall;

  // bin of a nonnegative sample, clamped to the last bin
  assign mag     = sample[hpbt_pkg::LEVEL_W-1:0];
  assign shifted = mag >> bin_shift;
  assign bin     = (shifted > hpbt_pkg::LEVEL_W'(hpbt_pkg::NUM_BINS - 1))
                 ? hpbt_pkg::BIN_W'(hpbt_pkg::NUM_BINS - 1)
                 : shifted[hpbt_pkg::BIN_W-1:0];

  assign cmd.start = accept && learn;
  assign cmd.init  = !started;
  assign cmd.bin   = bin;
  assign cmd.decay = hist_decay;

  hpbt_hist u_hist (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  // quantile = stop index scaled by bin width, saturated to the sample range
  assign q_wide = hpbt_pkg::QUANT_W'(stat.stop_idx) << bin_shift;
  assign q_sat  = (q_wide > hpbt_pkg::QUANT_W'(hpbt_pkg::SAMPLE_MAX))
                ? hpbt_pkg::SAMPLE_MAX
                : q_wide[hpbt_pkg::LEVEL_W-1:0];

  assign blend = hpbt_pkg::WEIGHT_ONE - {1'b0, baseline_decay};

  assign level      = baseline[hpbt_pkg::FRAC_W +: hpbt_pkg::LEVEL_W];
  assign resid_calc = enabled_reg
                    ? {sample_reg[hpbt_pkg::SAMPLE_BITS-1], sample_reg}
                      - {2'b00, level}
                    : {sample_reg[hpbt_pkg::SAMPLE_BITS-1], sample_reg};

  always_comb begin
    state_next = state;
    unique case (state)
      hpbt_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = learn ? hpbt_pkg::ST_HIST : hpbt_pkg::ST_FINISH;
        end
      end
      hpbt_pkg::ST_HIST: begin
        if (stat.done) begin
          state_next = init_reg ? hpbt_pkg::ST_FINISH : hpbt_pkg::ST_MUL_A;
        end
      end
      hpbt_pkg::ST_MUL_A: state_next = hpbt_pkg::ST_MUL_B;
      hpbt_pkg::ST_MUL_B: state_next = hpbt_pkg::ST_ADD;
      hpbt_pkg::ST_ADD:   state_next = hpbt_pkg::ST_FINISH;
      hpbt_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = hpbt_pkg::ST_IDLE;
        end
      end
      default: state_next = hpbt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpbt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // config writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_decay     <= '0;
      baseline_decay <= '0;
      bin_shift      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        hpbt_pkg::CFG_HIST_DECAY:     hist_decay     <= cfg_data;
        hpbt_pkg::CFG_BASELINE_DECAY: baseline_decay <= cfg_data;
        hpbt_pkg::CFG_BIN_SHIFT:      bin_shift      <= cfg_data[hpbt_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // word capture and baseline blend multipliers
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_reg  <= sample;
      enabled_reg <= enabled;
      init_reg    <= !started;
    end
    if (state == hpbt_pkg::ST_HIST && stat.done) begin
      q <= q_sat;
    end
    if (state == hpbt_pkg::ST_MUL_A) begin
      prod_a <= (hpbt_pkg::BASE_W + hpbt_pkg::FRAC_W)'(baseline)
              * (hpbt_pkg::BASE_W + hpbt_pkg::FRAC_W)'(baseline_decay);
    end
    if (state == hpbt_pkg::ST_MUL_B) begin
      // (q << 16) * (1 - b) >> 16 is exact, so no shift is needed here
      prod_b <= hpbt_pkg::BASE_W'(q) * hpbt_pkg::BASE_W'(blend);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started  <= 1'b0;
      baseline <= '0;
    end else begin
      if (state == hpbt_pkg::ST_HIST && stat.done && init_reg) begin
        // seeding word: baseline jumps to the sample
        started  <= 1'b1;
        baseline <= {sample_reg, {hpbt_pkg::FRAC_W{1'b0}}};
      end
      if (state == hpbt_pkg::ST_ADD) begin
        baseline <= prod_a[hpbt_pkg::FRAC_W +: hpbt_pkg::BASE_W] + prod_b;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == hpbt_pkg::ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == hpbt_pkg::ST_FINISH && out_free) begin
      residual       <= $signed(resid_calc);
      baseline_level <= level;
    end
  end

endmodule

@@ hw/rtl/hpbt_checker.sv @@
// Port-level checker for the percentile baseline tracker, with its bind.
`include "assert_macros.svh"

module hpbt_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    cfg_write,
  input logic [hpbt_pkg::CFG_IDX_W-1:0]          cfg_index,
  input logic [hpbt_pkg::FRAC_W-1:0]             cfg_data,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic signed [hpbt_pkg::SAMPLE_BITS-1:0] sample,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic signed [hpbt_pkg::RESID_W-1:0]     residual,
  input logic [hpbt_pkg::LEVEL_W-1:0]            baseline_level
);

  // one word at a time: a taken word blocks the input on the next cycle
  `ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall)

  // a new result only appears while a word is being worked on
  `ASSERT_IMPL(a_result_from_work, clk, rst, $rose(out_valid), $past(in_stall))

  // a stalled result holds
  `ASSERT_NEXT(a_result_holds, clk, rst, out_valid && out_stall,
    out_valid && $stable(residual) && $stable(baseline_level))

endmodule

bind histogram_percentile_baseline_tracker hpbt_checker u_checker (.*);

@@ dv/hpbt_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the baseline tracker: tracks the histogram and baseline, compares every word.
module hpbt_result_checker
  import hpbt_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [FRAC_W-1:0]             cfg_data,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [RESID_W-1:0]     residual,
  input  logic [LEVEL_W-1:0]            baseline_level,
  output int                            errors,
  output int                            pending,
  output int                            checked,
  output int                            learned
);

  localparam int SHOWN_MISMATCHES = 10;

  typedef struct packed {
    logic signed [RESID_W-1:0] residual;
    logic [LEVEL_W-1:0]        level;
  } result_word_t;

  // tracker state, mirrored from the block
  logic [63:0]       bin_wt [NUM_BINS];
  logic [63:0]       base_q16;
  bit                seeded;
  logic [FRAC_W-1:0] hist_decay_r;
  logic [FRAC_W-1:0] baseline_decay_r;
  logic [SHIFT_W-1:0] bin_shift_r;

  result_word_t pending_words[$];
  result_word_t want;
  int           fail_cnt;
  int           checked_cnt;
  int           learn_cnt;

  // Applies one sample to the tracker and returns the word it should produce.
  task automatic advance_tracker(input logic signed [SAMPLE_BITS-1:0] s,
                                 output result_word_t r);
    bit          enabled;
    logic [63:0] bin;
    logic [63:0] acc;
    logic [63:0] quant;
    logic [63:0] idx;
    logic [LEVEL_W-1:0] level;
    enabled = (hist_decay_r != 0) && (baseline_decay_r != 0);
    if (enabled && !s[SAMPLE_BITS-1]) begin
      learn_cnt++;
      bin = {48'b0, s} >> bin_shift_r;
      if (bin > 64'(NUM_BINS - 1)) bin = 64'(NUM_BINS - 1);
      if (!seeded) begin
        bin_wt[bin] = 64'(WEIGHT_ONE);
        base_q16 = {32'b0, s, 16'b0};
        seeded = 1'b1;
      end else begin
        for (int i = 0; i < NUM_BINS; i++)
          bin_wt[i] = (bin_wt[i] * 64'(hist_decay_r)) >> FRAC_W;
        bin_wt[bin] += 64'(WEIGHT_ONE) - 64'(hist_decay_r);
        // walk until the running sum reaches 5 percent (3277 in Q0.16)
        idx = '0;
        acc = '0;
        do begin
          acc += bin_wt[idx];
          idx++;
        end while (acc < 64'(QUANT_THRESHOLD) && idx < 64'(NUM_BINS));
        quant = idx << bin_shift_r;
        if (quant > 64'(SAMPLE_MAX)) quant = 64'(SAMPLE_MAX);
        base_q16 = (base_q16 * 64'(baseline_decay_r)
                    + (quant << FRAC_W) * (64'(WEIGHT_ONE) - 64'(baseline_decay_r)))
                   >> FRAC_W;
      end
    end
    level = base_q16[FRAC_W +: LEVEL_W];
    r.level = level;
    r.residual = enabled ? RESID_W'(s) - $signed({2'b00, level}) : RESID_W'(s);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BINS; i++) bin_wt[i] = '0;
      base_q16 = '0;
      seeded = 1'b0;
      hist_decay_r = '0;
      baseline_decay_r = '0;
      bin_shift_r = '0;
      pending_words.delete();
      fail_cnt = 0;
      checked_cnt = 0;
      learn_cnt = 0;
    end else begin
      // result side first: a word out always belongs to an earlier sample
      if (out_valid && !out_stall) begin
        if (pending_words.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= SHOWN_MISMATCHES)
            $display("checker: unexpected word residual %0d level %0d",
                     residual, baseline_level);
        end else begin
          want = pending_words.pop_front();
          if (want.residual !== residual || want.level !== baseline_level) begin
            fail_cnt++;
            if (fail_cnt <= SHOWN_MISMATCHES)
              $display("checker: word %0d residual exp %0d got %0d, level exp %0d got %0d",
                       checked_cnt, want.residual, residual, want.level, baseline_level);
          end
          checked_cnt++;
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_HIST_DECAY:     hist_decay_r = cfg_data;
          CFG_BASELINE_DECAY: baseline_decay_r = cfg_data;
          CFG_BIN_SHIFT:      bin_shift_r = cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_tracker(sample, want);
        pending_words = {pending_words, want};
      end
    end
    pending <= pending_words.size();
    errors  <= fail_cnt;
    checked <= checked_cnt;
    learned <= learn_cnt;
  end

endmodule

@@ dv/histogram_percentile_baseline_tracker_tb.sv @@
`timescale 1ns / 100ps
// Testbench top: drives samples and register writes into the baseline tracker, gives the verdict.
module histogram_percentile_baseline_tracker_tb;
  import hpbt_pkg::*;

  // index past the register list; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(3);

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 225;
  localparam int MAX_GAP       = 19;
  localparam int HOLD_AT       = 120;     // words sent before the long output hold-off
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 100;     // longer than a learning word takes
  localparam int LIMIT_CYCLES  = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [FRAC_W-1:0]             cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] sample    = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [RESID_W-1:0]     residual;
  logic [LEVEL_W-1:0]            baseline_level;

  int errors;
  int pending;
  int checked;
  int learned;

  bit          calm    = 1'b0;  // no idling on either side while set
  logic        rx_hold = 1'b0;  // long receiver hold-off
  int unsigned rx_wait = 0;
  int unsigned rx_next;
  int unsigned sent     = 0;
  int unsigned settings = 0;
  int unsigned cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  histogram_percentile_baseline_tracker dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .residual       (residual),
    .baseline_level (baseline_level)
  );

  hpbt_result_checker u_result_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .sample         (sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .residual       (residual),
    .baseline_level (baseline_level),
    .errors         (errors),
    .pending        (pending),
    .checked        (checked),
    .learned        (learned)
  );

  // Run limit; a hang anywhere ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: after each word it draws a wait, counted down only while a word
  // is offered. rx_hold stacks on top.
  always @(posedge clk) begin
    if (rst) begin
      rx_wait   <= 0;
      out_stall <= 1'b0;
    end else begin
      rx_next = rx_wait;
      if (out_valid && !out_stall)
        rx_next = calm ? 0 : $urandom_range(0, MAX_GAP);
      else if (out_valid && rx_next != 0)
        rx_next = rx_next - 1;
      rx_wait   <= rx_next;
      out_stall <= (rx_next != 0) || rx_hold;
    end
  end

  // Long hold-off on the result side while the sender keeps offering words,
  // so the output register fills and the block stalls its input.
  initial begin
    wait (sent >= HOLD_AT);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // One sample word; returns at the edge that takes it. The stall is read at
  // the falling edge, where it is settled for the next rising edge.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
    int unsigned gap;
    bit          stalled;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    sent++;
  endtask

  // Stops the input and waits until every expected word has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Writes the spare index first (ignored), then all three registers. Upper
  // data bits of the bin shift write are junk on purpose.
  task automatic set_regs(input logic [FRAC_W-1:0] hd, input logic [FRAC_W-1:0] bd,
                          input logic [SHIFT_W-1:0] bs);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_data  <= FRAC_W'($urandom);
    @(posedge clk);
    cfg_index <= CFG_HIST_DECAY;
    cfg_data  <= hd;
    @(posedge clk);
    cfg_index <= CFG_BASELINE_DECAY;
    cfg_data  <= bd;
    @(posedge clk);
    cfg_index <= CFG_BIN_SHIFT;
    cfg_data  <= {12'($urandom), bs};
    @(posedge clk);
    cfg_write <= 1'b0;
    settings++;
  endtask

  // Now and then zero, one or full scale, otherwise any fraction.
  function automatic logic [FRAC_W-1:0] pick_decay();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;            // learning off for this phase
    if (r == 1) return FRAC_W'(1);
    if (r == 2) return '1;
    return FRAC_W'($urandom);
  endfunction

  // Nearly half the samples land in a four-bin range at a per-phase cluster, so
  // the quantile walk has something to find; the rest are negatives, noise and values spread up to top.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int unsigned shift,
                                                               int unsigned center,
                                                               int unsigned top);
    int unsigned r;
    int unsigned v;
    r = $urandom_range(0, 99);
    if (r < 10) return SAMPLE_BITS'($urandom);
    if (r < 20) return {1'b1, 15'($urandom)};
    if (r < 65) v = center + $urandom_range(0, (4 << shift) - 1);
    else        v = $urandom_range(0, top);
    if (v > 32767) v = 32767;
    return SAMPLE_BITS'(v);
  endfunction

  initial begin
    logic [FRAC_W-1:0]  hd;
    logic [FRAC_W-1:0]  bd;
    logic [SHIFT_W-1:0] bs;
    int unsigned        top;
    int unsigned        center;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // registers at reset: learning off, residual is the sample itself
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sh0000);
    send_sample(16'shFFFF);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    drain();

    // first learning word seeds; then a negative word (still subtracts the
    // baseline), a word far past the last bin, and small ones
    set_regs(16'hFFFF, 16'h0001, 4'd0);
    send_sample(16'sd200);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    send_sample(16'sd0);
    send_sample(16'sd5);
    send_sample(16'sd63);
    drain();

    // widest bins: any stop index shifted by 15 saturates the quantile
    set_regs(16'h0001, 16'hFFFF, 4'd15);
    send_sample(16'sh7FFF);
    send_sample(16'sd1000);
    send_sample(16'sd0);
    drain();

    // histogram decay zero turns learning off mid-stream, state is kept
    set_regs(16'h0000, 16'hFFFF, 4'd15);
    send_sample(-16'sd5);
    send_sample(16'sd100);
    drain();
    set_regs(16'h8000, 16'h8000, 4'd4);
    send_sample(16'sd17);
    send_sample(16'sd1023);
    send_sample(16'sd40);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      calm <= (p % 4 == 3);
      hd = pick_decay();
      bd = pick_decay();
      bs = (p == 0) ? SHIFT_W'(0) : (p == 1) ? SHIFT_W'(15) : SHIFT_W'($urandom_range(0, 15));
      set_regs(hd, bd, bs);
      top = (NUM_BINS << bs) - 1;
      if (top > 32767) top = 32767;
      center = $urandom_range(0, top);
      repeat (PHASE_WORDS) send_sample(pick_sample(bs, center, top));
      drain();
    end
    calm <= 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d samples over %0d register settings, %0d of them learning updates",
             sent, settings, learned);
    $display("tb: %0d words checked, %0d mismatches, %0d still expected",
             checked, errors, pending);
    if (errors == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
